/* hdl/rth_pkg.sv */
// rth_pkg: shared types and constants for the RGB to HSI pixel converter.
// No dependencies.
`default_nettype none
package rth_pkg;

  localparam int XY_W   = 26;  // CORDIC vector width, covers the 1.65 gain
  localparam int Z_W    = 16;  // angle in turns * 65536
  localparam int SUM_W  = 10;  // R+G+B up to 765
  localparam int REM_W  = 18;  // 765*min up to 195075
  localparam int TAB_LEN = 24;

  localparam logic [Z_W-1:0] HALF_TURN = 16'd32768;
  localparam logic [9:0]     SAT_SCALE = 10'd765;
  localparam logic [7:0]     SAT_MAX   = 8'd255;
  localparam logic [14:0]    SQRT3_Q14 = 15'd28378;
  localparam logic [9:0]     THIRD_Q11 = 10'd683;  // round(2048/3)

  // One pixel as it moves down the cell row
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [Z_W-1:0]         z;
    logic                   hold;  // axis or gray: angle already final
    logic [REM_W-1:0]       rem;   // division remainder
    logic [SUM_W-1:0]       sum;
    logic [7:0]             quo;   // 765*min/sum, built msb first
    logic                   eof;
  } item_t;

  // atan(2^-i) in turns * 65536, rounded
  function automatic logic [Z_W-1:0] atan_tab(input int i);
    logic [Z_W-1:0] v;
    case (i)
      0:  v = 16'd8192;
      1:  v = 16'd4836;
      2:  v = 16'd2555;
      3:  v = 16'd1297;
      4:  v = 16'd651;
      5:  v = 16'd326;
      6:  v = 16'd163;
      7:  v = 16'd81;
      8:  v = 16'd41;
      9:  v = 16'd20;
      10: v = 16'd10;
      11: v = 16'd5;
      12: v = 16'd3;
      13: v = 16'd1;
      14: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* hdl/rth_prep.sv */
// rth_prep: entry stage; forms the CORDIC start vector, sum and min.
// Depends on rth_pkg.
`default_nettype none
module rth_prep import rth_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire logic       valid_in,
  input  wire logic [7:0] red,
  input  wire logic [7:0] green,
  input  wire logic [7:0] blue,
  input  wire logic       end_of_frame,
  output item_t           item,
  output logic            valid
);

  logic signed [10:0]     dx;
  logic signed [8:0]      dy;
  logic signed [XY_W-1:0] x0;
  logic signed [XY_W-1:0] y0;
  logic [7:0]             mn;
  item_t                  item_next;

  // start vector: X = (2R-G-B)*2^14, Y = (G-B)*sqrt3 in Q14
  always_comb begin
    dx = $signed({2'b00, red, 1'b0}) - $signed({3'b000, green}) - $signed({3'b000, blue});
    dy = $signed({1'b0, green}) - $signed({1'b0, blue});
    x0 = XY_W'(dx) <<< 14;
    y0 = XY_W'(dy) * $signed({1'b0, SQRT3_Q14});
    mn = (red < green) ? red : green;
    if (blue < mn) mn = blue;

    item_next.sum  = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
    item_next.rem  = REM_W'(mn) * REM_W'(SAT_SCALE);
    item_next.quo  = '0;
    item_next.eof  = end_of_frame;
    item_next.hold = (y0 == '0);
    item_next.x    = x0;
    item_next.y    = y0;
    item_next.z    = '0;
    // left half plane: turn by half a turn first
    if (x0 < 0) begin
      item_next.x = -x0;
      item_next.y = -y0;
      item_next.z = HALF_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item <= item_next;
    end
  end

endmodule
`default_nettype wire

/* hdl/rth_cell.sv */
// rth_cell: one CORDIC micro-rotation, plus one quotient bit in the first eight cells.
// Depends on rth_pkg.
`default_nettype none
module rth_cell import rth_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire logic  valid_in,
  input  wire item_t item_in,
  output item_t      item,
  output logic       valid
);

  localparam logic [Z_W-1:0] ANG = atan_tab(IDX);
  // quotient bit handled here; only meaningful in the first eight cells
  localparam int QB = (IDX < 8) ? 7 - IDX : 0;

  logic signed [XY_W-1:0] sx;
  logic signed [XY_W-1:0] sy;
  logic [REM_W-1:0]       dvs;
  item_t                  item_next;

  always_comb begin
    item_next = item_in;
    sx = item_in.x >>> IDX;
    sy = item_in.y >>> IDX;
    dvs = '0;
    // rotate toward the x axis
    if (!item_in.hold) begin
      if (item_in.y > 0) begin
        item_next.x = item_in.x + sy;
        item_next.y = item_in.y - sx;
        item_next.z = item_in.z + ANG;
      end else begin
        item_next.x = item_in.x - sy;
        item_next.y = item_in.y + sx;
        item_next.z = item_in.z - ANG;
      end
    end
    // restoring division step, quotient bit 7-IDX
    if (IDX < 8) begin
      dvs = REM_W'(item_in.sum) << QB;
      if (item_in.rem >= dvs) begin
        item_next.rem = item_in.rem - dvs;
        item_next.quo[QB] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item <= item_next;
    end
  end

endmodule
`default_nettype wire

/* hdl/rgb_to_hsi_pixel.sv */
// rgb_to_hsi_pixel: top level; entry stage, a row of CORDIC cells, output register.
// Depends on rth_pkg, rth_prep, rth_cell.
//
//  channel | valid     | ready     | payload
//  pixel   | pix_valid | pix_ready | red, green, blue, end_of_frame
//  result  | hsi_valid | hsi_ready | intensity, saturation, hue, last_out
//
// One pixel per clock while the result is not stalled. A pixel passes the entry
// stage, one cell per micro-rotation, and the output register, in that order.
// A stalled result freezes the whole row; pix_ready drops only then.
// Reset clears the valid bits only.
`default_nettype none
module rgb_to_hsi_pixel import rth_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       pix_valid,
  output logic            pix_ready,
  input  wire logic [7:0] red,
  input  wire logic [7:0] green,
  input  wire logic [7:0] blue,
  input  wire logic       end_of_frame,
  output logic            hsi_valid,
  input  wire logic       hsi_ready,
  output logic [7:0]      intensity,
  output logic [7:0]      saturation,
  output logic [7:0]      hue,
  output logic            last_out
);

  localparam int N = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;

  item_t      stg [0:N];
  logic [N:0] vld;
  logic       en;
  logic [19:0] third;
  logic [23:0] hue_prod;

  assign en        = !(hsi_valid && !hsi_ready);
  assign pix_ready = en;

  rth_prep u_prep (
    .clk, .rst, .en,
    .valid_in(pix_valid), .red, .green, .blue, .end_of_frame,
    .item(stg[0]), .valid(vld[0])
  );

  // cell row
  for (genvar i = 0; i < N; i++) begin : g_cell
    rth_cell #(.IDX(i)) u_cell (
      .clk, .rst, .en,
      .valid_in(vld[i]), .item_in(stg[i]),
      .item(stg[i+1]), .valid(vld[i+1])
    );
  end

  // final scaling: sum/3 by reciprocal, hue = turns*255 >> 16
  always_comb begin
    third    = 20'(stg[N].sum) * 20'(THIRD_Q11);
    hue_prod = {stg[N].z, 8'd0} - 24'(stg[N].z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hsi_valid <= 1'b0;
    end else if (en) begin
      hsi_valid <= vld[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      intensity  <= third[18:11];
      saturation <= (stg[N].sum == '0) ? 8'd0 : SAT_MAX - stg[N].quo;
      hue        <= hue_prod[23:16];
      last_out   <= stg[N].eof;
    end
  end

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk) rst |=> !hsi_valid && vld == '0)
    else $error("pipeline not empty after reset");
  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    hsi_valid && !hsi_ready |=> $stable(vld))
    else $error("cell row moved during stall");
  a_ready_free: assert property (@(posedge clk) disable iff (rst) !hsi_valid |-> pix_ready)
    else $error("input blocked with empty output");
`endif

endmodule
`default_nettype wire

/* tb/rth_checker.sv */
// rth_checker: watches the pixel and result channels of rgb_to_hsi_pixel,
// predicts intensity, saturation and hue per pixel and compares them.
// Depends on nothing but the port signals.
`timescale 1ns / 100ps
module rth_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       pix_valid,
  input  logic       pix_ready,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic       end_of_frame,
  input  logic       hsi_valid,
  input  logic       hsi_ready,
  input  logic [7:0] intensity,
  input  logic [7:0] saturation,
  input  logic [7:0] hue,
  input  logic       last_out,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic [7:0] inten;
    logic [7:0] sat;
    logic [7:0] hue;
    logic       eof;
  } hsi_t;

  hsi_t hsi_queue[$];

  // arctan(2^-i) in turns * 65536
  function automatic longint atan_turns(input int i);
    longint t[15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                      41, 20, 10, 5, 3, 1, 1};
    return (i < 15) ? t[i] : 0;
  endfunction

  // hue angle in 16-bit turns from the vector (x, y)
  function automatic logic [15:0] hue_angle(input longint xi, input longint yi);
    longint x, y, z, dx, dy;
    int n;
    x = xi;
    y = yi;
    z = 0;
    n = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    if (x == 0 && y == 0) return 16'd0;
    if (y == 0) return (x > 0) ? 16'd0 : 16'd32768;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32768;
    end
    for (int i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += atan_turns(i);
      end else begin
        x -= dx;
        y += dy;
        z -= atan_turns(i);
      end
    end
    return z[15:0];
  endfunction

  function automatic hsi_t convert_pixel(input logic [7:0] r, g, b, input logic eof);
    hsi_t res;
    int sum, mn;
    longint x, y, turns;
    sum = r + g + b;
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    res.inten = 8'(sum / 3);
    res.sat = (sum != 0) ? 8'(255 - (765 * mn) / sum) : 8'd0;
    x = (2 * longint'(r) - g - b) * 16384;
    y = (longint'(g) - b) * 28378;
    turns = hue_angle(x, y);
    res.hue = 8'((turns * 255) >> 16);
    res.eof = eof;
    return res;
  endfunction

  assign pending = hsi_queue.size();

  always @(posedge clk) begin
    hsi_t exp_item;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (pix_valid && pix_ready)
        hsi_queue.push_back(convert_pixel(red, green, blue, end_of_frame));
      if (hsi_valid && hsi_ready) begin
        if (hsi_queue.size() == 0) begin
          $error("result item with no pixel pending");
          fail_count <= fail_count + 1;
        end else begin
          exp_item = hsi_queue.pop_front();
          if (exp_item.inten !== intensity || exp_item.sat !== saturation ||
              exp_item.hue !== hue || exp_item.eof !== last_out) begin
            fail_count <= fail_count + 1;
            if (exp_item.inten !== intensity)
              $error("intensity: expected %0d, got %0d", exp_item.inten, intensity);
            if (exp_item.sat !== saturation)
              $error("saturation: expected %0d, got %0d", exp_item.sat, saturation);
            if (exp_item.hue !== hue)
              $error("hue: expected %0d, got %0d", exp_item.hue, hue);
            if (exp_item.eof !== last_out)
              $error("last_out: expected %0d, got %0d", exp_item.eof, last_out);
          end
        end
      end
    end
  end

endmodule

/* tb/testbench.sv */
// testbench: drives pixels into rgb_to_hsi_pixel with bursty valid and a
// stalling receiver; checking is done by rth_checker.
// Depends on rgb_to_hsi_pixel and rth_checker.
`timescale 1ns / 100ps
module testbench;

  localparam int STEPS = 16;
  localparam int LATENCY = STEPS + 2;
  localparam int RANDOM_ITEMS = 1450;

  logic       clk = 0;
  logic       rst = 1;
  logic       pix_valid = 0;
  logic       pix_ready;
  logic [7:0] red = 0, green = 0, blue = 0;
  logic       end_of_frame = 0;
  logic       hsi_valid;
  logic       hsi_ready = 0;
  logic [7:0] intensity, saturation, hue;
  logic       last_out;
  int         fail_count;
  int         pending;
  bit         stim_done = 0;

  rgb_to_hsi_pixel #(.CORDIC_STEPS(STEPS)) dut (
    .clk, .rst, .pix_valid, .pix_ready, .red, .green, .blue, .end_of_frame,
    .hsi_valid, .hsi_ready, .intensity, .saturation, .hue, .last_out
  );

  rth_checker #(.CORDIC_STEPS(STEPS)) checker_i (
    .clk, .rst, .pix_valid, .pix_ready, .red, .green, .blue, .end_of_frame,
    .hsi_valid, .hsi_ready, .intensity, .saturation, .hue, .last_out,
    .fail_count, .pending
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // send one item; valid stays up through back-to-back items
  task automatic send_pixel(input logic [7:0] r, g, b, input logic eof);
    red <= r;
    green <= g;
    blue <= b;
    end_of_frame <= eof;
    pix_valid <= 1'b1;
    @(posedge clk);
    while (!pix_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pause_sender(input int n);
    pix_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // receiver: alternates stall phases with free-running stretches
  initial begin
    int mode;
    @(negedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 60)) begin
        case (mode)
          0: hsi_ready <= 1'b1;
          1: hsi_ready <= ($urandom_range(0, 3) != 0);
          2: hsi_ready <= ($urandom_range(0, 1) == 1);
          default: hsi_ready <= ($urandom_range(0, 4) == 0);
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin
    logic [7:0] r, g, b;
    int burst, k;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // extremes, grays, axes and each half plane
    send_pixel(0, 0, 0, 0);
    send_pixel(255, 255, 255, 1);
    send_pixel(128, 128, 128, 0);
    send_pixel(255, 0, 0, 0);
    send_pixel(0, 255, 0, 0);
    send_pixel(0, 0, 255, 1);
    send_pixel(255, 255, 0, 0);
    send_pixel(0, 255, 255, 0);
    send_pixel(255, 0, 255, 0);
    send_pixel(0, 128, 128, 0);
    send_pixel(200, 100, 100, 0);
    send_pixel(1, 0, 0, 0);
    send_pixel(0, 0, 1, 0);
    send_pixel(0, 1, 0, 0);
    send_pixel(255, 254, 255, 0);
    send_pixel(254, 255, 255, 0);
    send_pixel(255, 255, 254, 0);
    send_pixel(170, 85, 85, 0);
    send_pixel(100, 200, 0, 1);
    send_pixel(85, 170, 255, 0);
    pause_sender(3);
    k = 0;
    while (k < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst && k < RANDOM_ITEMS; j++, k++) begin
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        case ($urandom_range(0, 9))
          0: begin g = r; b = r; end
          1: b = g;
          2: begin r = 8'($urandom_range(0, 3)); g = 8'($urandom_range(0, 3));
                   b = 8'($urandom_range(0, 3)); end
          3: r = 8'hff;
          default: ;
        endcase
        send_pixel(r, g, b, ($urandom_range(0, 15) == 0));
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
    end
    pix_valid <= 1'b0;
    stim_done = 1;
  end

  initial begin
    @(negedge rst);
    wait (stim_done);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
